FILE: rtl/byte_level_bpe_char_codec_macros.svh
// Assertion macros shared by the byte-level codec checker.
// Holds nothing but macro definitions; no other file is needed.
`ifndef BYTE_LEVEL_BPE_CHAR_CODEC_MACROS_SVH
`define BYTE_LEVEL_BPE_CHAR_CODEC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bblc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bblc assertion failed");

`endif

FILE: rtl/bblc_pkg.sv
// Shared types, constants and mapping functions of the byte-level codec.
// Has no dependencies; every other file but the macro header imports it.
`default_nettype none

package bblc_pkg;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_token;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       token_done;
    logic       unmapped;
  } out_req_t;

  // One queue entry: one or two output bytes that come from one request.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two_bytes;
    logic       eot;
    logic       unmapped;
  } bblc_entry_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int CPW = 21;

  localparam logic [7:0] UTF8_LEAD2  = 8'hC0;
  localparam logic [7:0] UTF8_CONT   = 8'h80;
  localparam logic [7:0] SUBST_BYTE  = 8'h3F;

  // Raw byte to its byte-level code point.
  function automatic logic [8:0] byte_to_code(input logic [7:0] b);
    logic [8:0] r;
    if (b <= 8'd32) begin
      r = 9'd256 + {1'b0, b};
    end else if (b >= 8'd127 && b <= 8'd160) begin
      r = {1'b0, b} + 9'd162;
    end else if (b == 8'd173) begin
      r = 9'd323;
    end else begin
      r = {1'b0, b};
    end
    return r;
  endfunction

  // Code point back to its raw byte; bit 8 is set when a byte exists.
  function automatic logic [8:0] code_to_byte(input logic [CPW-1:0] cp);
    logic [CPW-1:0] d;
    logic [8:0]     r;
    d = '0;
    r = '0;
    if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
        (cp >= 21'd174 && cp <= 21'd255)) begin
      r = {1'b1, cp[7:0]};
    end else if (cp >= 21'd256 && cp <= 21'd288) begin
      d = cp - 21'd256;
      r = {1'b1, d[7:0]};
    end else if (cp >= 21'd289 && cp <= 21'd322) begin
      d = cp - 21'd162;
      r = {1'b1, d[7:0]};
    end else if (cp == 21'd323) begin
      r = {1'b1, 8'd173};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/byte_level_bpe_char_codec.sv
// Byte-level BPE character codec, top level. Each request carries one byte of a
// token and a flag on its last byte. With direction 0 (encode, the reset value)
// a raw byte becomes its byte-level code point sent as UTF-8: one output byte
// for code points below 0x80, two otherwise. With direction 1 (decode) UTF-8
// sequences of one to four bytes are assembled and mapped back to raw bytes;
// a code point with no raw byte comes out as '?' with the unmapped flag set,
// and a sequence cut short by the end of the token is closed with zero bits.
// Writing the direction register drops any partial sequence; write it only
// while no request is in flight. Both channels use valid/stall: a request is
// taken at a rising edge where valid is high and stall is low. A new request
// can be taken every cycle while the queue has room; the output side moves one
// byte per cycle while it is not stalled. A decode request yields at most one
// output byte and an encode request one or two (two for every byte whose code
// point is 0x80 or above), sent out by the single-byte output register of the
// back end. A result passes through the queue and then the output register.
// Depends on bblc_pkg, bblc_front, bblc_queue and bblc_back.
`default_nettype none

module byte_level_bpe_char_codec (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  bblc_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  wire                out_stall,
  output bblc_pkg::out_req_t out_req,
  input  wire                cfg_wr_en,
  input  wire                cfg_wr_data
);
  import bblc_pkg::*;

  // Front to queue.
  logic        push;
  bblc_entry_t push_data;
  logic        q_full;

  // Queue to back.
  logic        pop;
  logic        q_valid;
  bblc_entry_t q_data;

  // The front end holds the direction register and the decode state. It takes
  // a request whenever the queue has room and pushes one entry per request
  // that yields output; a decode byte that opens or continues a sequence
  // pushes nothing.
  bblc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .cfg_wr_en (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // The queue absorbs bursts of two-byte entries so that the front end keeps
  // accepting while the back end sends the second byte of an entry.
  bblc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // The back end turns each entry into one or two output requests and holds
  // them in the output register until the receiver takes them.
  bblc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule

`default_nettype wire

FILE: rtl/bblc_front.sv
// Front end of the byte-level codec: accepts requests, maps or assembles them.
// Depends on bblc_pkg; pushes finished work into the queue.
`default_nettype none

module bblc_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  bblc_pkg::in_req_t     in_req,
  input  wire                   cfg_wr_en,
  input  wire                   cfg_wr_data,
  input  wire                   q_full,
  output logic                  push,
  output bblc_pkg::bblc_entry_t push_data
);
  import bblc_pkg::*;

  dir_t           direction_r, direction_nxt;
  logic [1:0]     pend_r, pend_nxt;
  logic [CPW-1:0] acc_r, acc_nxt;

  logic           accept;
  logic [7:0]     b;
  logic           eot;
  logic [8:0]     enc_cp;
  logic [CPW-1:0] ext;
  logic [CPW-1:0] cont;
  logic [CPW-1:0] dec_cp;
  logic           dec_ready;
  logic [1:0]     dec_pend;
  logic [CPW-1:0] dec_acc;
  logic [8:0]     map;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_req.data_byte;
  assign eot      = in_req.end_of_token;
  assign enc_cp   = byte_to_code(b);
  assign ext      = {{(CPW-6){1'b0}}, b[5:0]};

  always_comb begin
    unique case (pend_r)
      2'd1:    cont = ext;
      2'd2:    cont = ext << 6;
      2'd3:    cont = ext << 12;
      default: cont = '0;
    endcase
  end

  // UTF-8 assembly for one byte.
  always_comb begin
    dec_ready = 1'b0;
    dec_cp    = '0;
    dec_pend  = pend_r;
    dec_acc   = acc_r;
    if (pend_r == 2'd0) begin
      priority if (b[7] == 1'b0) begin
        dec_cp    = {13'd0, b};
        dec_ready = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        dec_acc  = {{(CPW-11){1'b0}}, b[4:0], 6'd0};
        dec_pend = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        dec_acc  = {{(CPW-16){1'b0}}, b[3:0], 12'd0};
        dec_pend = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        dec_acc  = {b[2:0], 18'd0};
        dec_pend = 2'd3;
      end else begin
        // Stray continuation or over-long lead stands for itself.
        dec_cp    = {13'd0, b};
        dec_ready = 1'b1;
      end
    end else begin
      dec_acc  = acc_r | cont;
      dec_pend = pend_r - 2'd1;
      if (dec_pend == 2'd0) begin
        dec_cp    = dec_acc;
        dec_ready = 1'b1;
        dec_acc   = '0;
      end
    end
    if (!dec_ready && eot) begin
      // Token ended mid-sequence: missing bits are zero.
      dec_cp    = dec_acc;
      dec_ready = 1'b1;
      dec_pend  = 2'd0;
      dec_acc   = '0;
    end
  end

  assign map = code_to_byte(dec_cp);

  always_comb begin
    push_data = '0;
    push_data.eot = eot;
    if (direction_r == DIR_ENCODE) begin
      push = accept;
      if (enc_cp < 9'h080) begin
        push_data.byte0 = enc_cp[7:0];
      end else begin
        push_data.byte0     = UTF8_LEAD2 | {5'd0, enc_cp[8:6]};
        push_data.byte1     = UTF8_CONT | {2'd0, enc_cp[5:0]};
        push_data.two_bytes = 1'b1;
      end
    end else begin
      push = accept && dec_ready;
      push_data.byte0    = map[8] ? map[7:0] : SUBST_BYTE;
      push_data.unmapped = !map[8];
    end
  end

  always_comb begin
    direction_nxt = direction_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    if (cfg_wr_en) begin
      direction_nxt = dir_t'(cfg_wr_data);
      pend_nxt      = 2'd0;
      acc_nxt       = '0;
    end else if (accept && direction_r == DIR_DECODE) begin
      pend_nxt = dec_pend;
      acc_nxt  = dec_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      pend_r      <= 2'd0;
      acc_r       <= '0;
    end else begin
      direction_r <= direction_nxt;
      pend_r      <= pend_nxt;
      acc_r       <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bblc_queue.sv
// Short queue between the front and back ends of the byte-level codec.
// Depends on bblc_pkg for the entry type and depth.
`default_nettype none

module bblc_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  bblc_pkg::bblc_entry_t push_data,
  input  wire                   pop,
  output logic                  full,
  output logic                  q_valid,
  output bblc_pkg::bblc_entry_t q_data
);
  import bblc_pkg::*;

  bblc_entry_t    mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  assign full    = (count_r == QCW'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bblc_back.sv
// Back end of the byte-level codec: drains queue entries one byte per cycle,
// unless the output stalls. Depends on bblc_pkg; owns the output register.
`default_nettype none

module bblc_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  input  bblc_pkg::bblc_entry_t q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_stall,
  output bblc_pkg::out_req_t    out_req
);
  import bblc_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  out_req_t   out_req_r, out_req_nxt;
  logic       sec_pend_r, sec_pend_nxt;
  logic [7:0] sec_byte_r, sec_byte_nxt;
  logic       sec_eot_r, sec_eot_nxt;
  logic       load;

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;
  assign load      = !out_valid_r || !out_stall;
  assign pop       = load && !sec_pend_r && q_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_req_nxt   = out_req_r;
    sec_pend_nxt  = sec_pend_r;
    sec_byte_nxt  = sec_byte_r;
    sec_eot_nxt   = sec_eot_r;
    if (load) begin
      if (sec_pend_r) begin
        out_valid_nxt           = 1'b1;
        out_req_nxt.out_byte    = sec_byte_r;
        out_req_nxt.last_of_run = 1'b1;
        out_req_nxt.token_done  = sec_eot_r;
        out_req_nxt.unmapped    = 1'b0;
        sec_pend_nxt            = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt           = 1'b1;
        out_req_nxt.out_byte    = q_data.byte0;
        out_req_nxt.last_of_run = !q_data.two_bytes;
        out_req_nxt.token_done  = q_data.eot && !q_data.two_bytes;
        out_req_nxt.unmapped    = q_data.unmapped;
        sec_pend_nxt            = q_data.two_bytes;
        sec_byte_nxt            = q_data.byte1;
        sec_eot_nxt             = q_data.eot;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_req_r  <= out_req_nxt;
    sec_byte_r <= sec_byte_nxt;
    sec_eot_r  <= sec_eot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_pend_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_pend_r  <= sec_pend_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bblc_checker.sv
// Port-level checker for the byte-level codec, bound to the top level.
// Depends on bblc_pkg and byte_level_bpe_char_codec_macros.svh.
`default_nettype none
`include "byte_level_bpe_char_codec_macros.svh"

module bblc_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_stall,
  input bblc_pkg::out_req_t out_req
);
  import bblc_pkg::*;

  // A stalled output request holds.
  `BBLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_req))

  // The end of a token is only marked on the last byte of a run.
  `BBLC_ASSERT_NOW(a_done_last, clk, rst_n, out_valid && !out_req.last_of_run, !out_req.token_done)

  // Only a UTF-8 lead byte of a two-byte sequence opens a run of two.
  `BBLC_ASSERT_NOW(a_lead_byte, clk, rst_n, out_valid && !out_req.last_of_run, out_req.out_byte[7:6] == 2'b11 && !out_req.unmapped)

  // The second byte of a run follows its lead byte with no gap.
  `BBLC_ASSERT_NEXT(a_second_next, clk, rst_n, out_valid && !out_stall && !out_req.last_of_run, out_valid && out_req.last_of_run && out_req.out_byte[7:6] == 2'b10)

  // An unmapped code point always comes out as the substitute byte.
  `BBLC_ASSERT_NOW(a_subst, clk, rst_n, out_valid && out_req.unmapped, out_req.out_byte == SUBST_BYTE)

endmodule

bind byte_level_bpe_char_codec bblc_checker u_bblc_checker (.*);

`default_nettype wire
